FILE: hw/rtl/hemisphere_direction_sampler_assert.svh
// Assertion macros for the direction sampler checker.
`ifndef HEMISPHERE_DIRECTION_SAMPLER_ASSERT_SVH
`define HEMISPHERE_DIRECTION_SAMPLER_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define HDS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define HDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/hds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hds_pkg;

    localparam int IN_BITS       = 16;
    localparam int OUT_FRAC_BITS = 15;
    localparam int SQRT_BITS     = 32;
    localparam int SERIES_CELLS  = 6;

    localparam logic [31:0] ONE31       = 32'h8000_0000;
    localparam logic [31:0] HALF_PI_Q31 = 32'd3373259426;

    localparam int COS_DIV [SERIES_CELLS] = '{132, 90, 56, 30, 12, 2};
    localparam int SIN_DIV [SERIES_CELLS] = '{110, 72, 42, 20, 6, 0};

    typedef struct packed {
        logic               func;
        logic [IN_BITS-1:0] u_azimuth;
        logic [IN_BITS-1:0] u_polar;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_FRAC_BITS:0] dir_x;
        logic signed [OUT_FRAC_BITS:0] dir_y;
        logic [OUT_FRAC_BITS-1:0]      dir_z;
    } t_out_item;

    typedef struct packed {
        logic [63:0] rem_s;
        logic [63:0] rem_c;
        logic [31:0] root_s;
        logic [31:0] root_c;
        logic [1:0]  quad;
        logic        mirror;
        logic [29:0] r;
        logic [31:0] a;
        logic [31:0] a2;
        logic [31:0] hc;
        logic [31:0] hs;
        logic [31:0] xc;
        logic [31:0] xs;
        logic [63:0] mc;
        logic [63:0] ms;
        logic [63:0] px;
        logic [63:0] py;
        logic        nx;
        logic        ny;
    } t_ctx;

    function automatic logic [OUT_FRAC_BITS:0] to_signed_out(logic [63:0] p, logic neg);
        logic [63:0] m;
        logic [63:0] lim;
        m   = (p + (64'd1 << (62 - OUT_FRAC_BITS - 1))) >> (62 - OUT_FRAC_BITS);
        lim = 64'd1 << OUT_FRAC_BITS;
        if (neg) begin
            if (m > lim) begin
                m = lim;
            end
            m = 64'd0 - m;
        end else if (m > lim - 64'd1) begin
            m = lim - 64'd1;
        end
        return m[OUT_FRAC_BITS:0];
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/hds_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module hds_sqrt_cell
    import hds_pkg::*;
#(
    parameter int K = 31
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_en,
    input  wire   i_valid,
    input  t_ctx  i_ctx,
    output logic  o_valid,
    output t_ctx  o_ctx
);

    logic [64:0] inc_s;
    logic [64:0] inc_c;
    t_ctx        n_ctx;
    t_ctx        r_ctx;
    logic        r_valid;

    always_comb begin
        n_ctx = i_ctx;
        inc_s = (65'(i_ctx.root_s) << (K + 1)) + (65'd1 << (2 * K));
        inc_c = (65'(i_ctx.root_c) << (K + 1)) + (65'd1 << (2 * K));
        if ({1'b0, i_ctx.rem_s} >= inc_s) begin
            n_ctx.rem_s  = i_ctx.rem_s - inc_s[63:0];
            n_ctx.root_s = i_ctx.root_s | (32'd1 << K);
        end
        if ({1'b0, i_ctx.rem_c} >= inc_c) begin
            n_ctx.rem_c  = i_ctx.rem_c - inc_c[63:0];
            n_ctx.root_c = i_ctx.root_c | (32'd1 << K);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctx <= n_ctx;
        end
    end

    assign o_valid = r_valid;
    assign o_ctx   = r_ctx;

endmodule
`default_nettype wire

FILE: hw/rtl/hds_series_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module hds_series_cell
    import hds_pkg::*;
#(
    parameter int DC = 132,
    parameter int DS = 110
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_en,
    input  wire   i_valid,
    input  t_ctx  i_ctx,
    output logic  o_valid,
    output t_ctx  o_ctx
);

    localparam int          DS_SAFE = (DS == 0) ? 1 : DS;
    localparam logic [31:0] DC32    = 32'(DC);
    localparam logic [31:0] DS32    = 32'(DS_SAFE);
    localparam logic [31:0] MC      = 32'((64'd1 << 31) / DC);
    localparam logic [31:0] MS      = 32'((64'd1 << 31) / DS_SAFE);

    t_ctx        n_c1, n_c2, n_c3;
    t_ctx        r_c1, r_c2, r_c3;
    logic [2:0]  r_v;
    logic [63:0] pc, ps;
    logic [31:0] q0c, q0s, remc, rems, qc, qs;

    always_comb begin
        n_c1    = i_ctx;
        pc      = 64'(i_ctx.a2) * 64'(i_ctx.hc);
        ps      = 64'(i_ctx.a2) * 64'(i_ctx.hs);
        n_c1.xc = pc[62:31];
        n_c1.xs = ps[62:31];
    end

    always_comb begin
        n_c2    = r_c1;
        n_c2.mc = 64'(r_c1.xc) * 64'(MC);
        n_c2.ms = 64'(r_c1.xs) * 64'(MS);
    end

    always_comb begin
        n_c3 = r_c2;
        q0c  = r_c2.mc[62:31];
        q0s  = r_c2.ms[62:31];
        remc = r_c2.xc - 32'(64'(q0c) * 64'(DC32));
        rems = r_c2.xs - 32'(64'(q0s) * 64'(DS32));
        qc   = q0c + 32'(remc >= DC32);
        qs   = q0s + 32'(rems >= DS32);
        n_c3.hc = ONE31 - qc;
        if (DS != 0) begin
            n_c3.hs = ONE31 - qs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c1 <= n_c1;
            r_c2 <= n_c2;
            r_c3 <= n_c3;
        end
    end

    assign o_valid = r_v[2];
    assign o_ctx   = r_c3;

endmodule
`default_nettype wire

FILE: hw/rtl/hemisphere_direction_sampler.sv
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_ready  i_data (func, u_azimuth, u_polar)
// output    out        o_valid / i_ready  o_data (dir_x, dir_y, dir_z)
//
// One transaction enters per cycle unless the chain stalls. The chain runs r_f, r_a, r_b,
// six three-stage series cells, 32 one-bit square root cells, then r_cs, r_d and r_out.
// The whole chain advances together whenever the output register is empty or taken.
// Synchronous active-low reset clears every stage valid; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module hemisphere_direction_sampler
    import hds_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  wire       i_ready,
    output t_out_item o_data
);

    localparam int          ZS   = 31 - OUT_FRAC_BITS;
    localparam logic [63:0] ZRND = (ZS == 0) ? 64'd0 : (64'd1 << (ZS - 1));
    localparam logic [63:0] ZLIM = (64'd1 << OUT_FRAC_BITS) - 64'd1;

    logic        en;
    t_ctx        n_f, n_a, n_b, n_cs, n_d;
    t_ctx        r_f, r_a, r_b, r_cs, r_d;
    logic        r_v_f, r_v_a, r_v_b, r_v_cs, r_v_d, r_v_e;
    t_out_item   n_out, r_out;

    logic [31:0] t32, v32;
    logic [30:0] v31;
    logic [63:0] sq, pa, pa2, psin;
    logic [31:0] c, s, cx, sy;
    logic        nx, ny;
    logic [63:0] z;

    t_ctx        w_ser_ctx [SERIES_CELLS+1];
    logic [SERIES_CELLS:0] w_ser_v;
    t_ctx        w_sq_ctx [SQRT_BITS+1];
    logic [SQRT_BITS:0]    w_sq_v;

    assign en      = !r_v_e || i_ready;
    assign o_ready = en;

    always_comb begin
        n_f      = '0;
        t32      = 32'(i_data.u_azimuth) << (32 - IN_BITS);
        v32      = 32'(i_data.u_polar) << (32 - IN_BITS);
        v31      = v32[31:1];
        sq       = 64'(v31) * 64'(v31);
        if (!i_data.func) begin
            n_f.rem_c = sq;
            n_f.rem_s = (64'd1 << 62) - sq;
        end else begin
            n_f.rem_c = (64'(ONE31) - 64'(v31)) << 31;
            n_f.rem_s = 64'(v31) << 31;
        end
        n_f.quad   = t32[31:30];
        n_f.mirror = t32[29:0] > 30'h2000_0000;
        n_f.r      = n_f.mirror ? 30'(31'h4000_0000 - 31'(t32[29:0])) : t32[29:0];
        n_f.hc     = ONE31;
        n_f.hs     = ONE31;
    end

    always_comb begin
        n_a   = r_f;
        pa    = 64'(r_f.r) * 64'(HALF_PI_Q31);
        n_a.a = pa[61:30];
    end

    always_comb begin
        n_b    = r_a;
        pa2    = 64'(r_a.a) * 64'(r_a.a);
        n_b.a2 = pa2[62:31];
    end

    assign w_ser_ctx[0] = r_b;
    assign w_ser_v[0]   = r_v_b;

    for (genvar gi = 0; gi < SERIES_CELLS; gi++) begin : g_series
        hds_series_cell #(
            .DC (COS_DIV[gi]),
            .DS (SIN_DIV[gi])
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_ser_v[gi]),
            .i_ctx   (w_ser_ctx[gi]),
            .o_valid (w_ser_v[gi+1]),
            .o_ctx   (w_ser_ctx[gi+1])
        );
    end

    assign w_sq_ctx[0] = w_ser_ctx[SERIES_CELLS];
    assign w_sq_v[0]   = w_ser_v[SERIES_CELLS];

    for (genvar gk = 0; gk < SQRT_BITS; gk++) begin : g_sqrt
        hds_sqrt_cell #(
            .K (SQRT_BITS - 1 - gk)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_sq_v[gk]),
            .i_ctx   (w_sq_ctx[gk]),
            .o_valid (w_sq_v[gk+1]),
            .o_ctx   (w_sq_ctx[gk+1])
        );
    end

    always_comb begin
        n_cs    = w_sq_ctx[SQRT_BITS];
        psin    = 64'(w_sq_ctx[SQRT_BITS].a) * 64'(w_sq_ctx[SQRT_BITS].hs);
        n_cs.hs = psin[62:31];
    end

    always_comb begin
        n_d = r_cs;
        c   = r_cs.mirror ? r_cs.hs : r_cs.hc;
        s   = r_cs.mirror ? r_cs.hc : r_cs.hs;
        unique case (r_cs.quad)
            2'd0: begin
                cx = c; sy = s; nx = 1'b0; ny = 1'b0;
            end
            2'd1: begin
                cx = s; sy = c; nx = 1'b1; ny = 1'b0;
            end
            2'd2: begin
                cx = c; sy = s; nx = 1'b1; ny = 1'b1;
            end
            default: begin
                cx = s; sy = c; nx = 1'b0; ny = 1'b1;
            end
        endcase
        n_d.px = 64'(r_cs.root_s) * 64'(cx);
        n_d.py = 64'(r_cs.root_s) * 64'(sy);
        n_d.nx = nx;
        n_d.ny = ny;
    end

    always_comb begin
        n_out.dir_x = to_signed_out(r_d.px, r_d.nx);
        n_out.dir_y = to_signed_out(r_d.py, r_d.ny);
        z           = (64'(r_d.root_c) + ZRND) >> ZS;
        if (z > ZLIM) begin
            z = ZLIM;
        end
        n_out.dir_z = z[OUT_FRAC_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_f  <= 1'b0;
            r_v_a  <= 1'b0;
            r_v_b  <= 1'b0;
            r_v_cs <= 1'b0;
            r_v_d  <= 1'b0;
            r_v_e  <= 1'b0;
        end else if (en) begin
            r_v_f  <= i_valid;
            r_v_a  <= r_v_f;
            r_v_b  <= r_v_a;
            r_v_cs <= w_sq_v[SQRT_BITS];
            r_v_d  <= r_v_cs;
            r_v_e  <= r_v_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f   <= n_f;
            r_a   <= n_a;
            r_b   <= n_b;
            r_cs  <= n_cs;
            r_d   <= n_d;
            r_out <= n_out;
        end
    end

    assign o_valid = r_v_e;
    assign o_data  = r_out;

endmodule
`default_nettype wire

FILE: hw/rtl/hds_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "hemisphere_direction_sampler_assert.svh"
module hds_assert_checker
    import hds_pkg::*;
(
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_valid,
    input wire       o_ready,
    input t_in_item  i_data,
    input wire       o_valid,
    input wire       i_ready,
    input t_out_item o_data
);

    // hold a waiting input transaction
    `HDS_ASSERT_NEXT(a_in_hold, i_valid && !o_ready, i_valid && $stable(i_data), "waiting input changed")
    // hold a stalled result
    `HDS_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_data), "stalled result changed")
    // advance whenever the output slot frees
    `HDS_ASSERT_NOW(a_ready_flow, 1'b1, o_ready == (!o_valid || i_ready), "ready does not follow output slot")
    // results appear only on an advancing edge
    `HDS_ASSERT_NOW(a_rise_adv, $rose(o_valid), $past(o_ready), "result appeared while stalled")
    // dir_x and dir_y never both hit minus one
    `HDS_ASSERT_NOW(a_not_both_min, o_valid, !(o_data.dir_x[OUT_FRAC_BITS] && o_data.dir_x[OUT_FRAC_BITS-1:0] == '0 && o_data.dir_y[OUT_FRAC_BITS] && o_data.dir_y[OUT_FRAC_BITS-1:0] == '0), "both components at minus one")

endmodule

bind hemisphere_direction_sampler hds_assert_checker u_hds_checker (.*);
`default_nettype wire

FILE: bench/hds_checker.sv
`timescale 1ns / 1ps
module hds_checker
    import hds_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_valid,
    input  wire       o_ready,
    input  t_in_item  i_data,
    input  wire       o_valid,
    input  wire       i_ready,
    input  t_out_item o_data,
    output int        o_errors,
    output int        o_pending,
    output int        o_results
);

    t_out_item dir_queue[$];

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] taylor(logic [63:0] a2, logic is_sine);
        logic [63:0] h;
        logic [63:0] divs [6];
        int          count;
        if (is_sine) begin
            divs  = '{110, 72, 42, 20, 6, 1};
            count = 5;
        end else begin
            divs  = '{132, 90, 56, 30, 12, 2};
            count = 6;
        end
        h = 64'd1 << 31;
        for (int i = 0; i < count; i++) h = (64'd1 << 31) - ((a2 * h) >> 31) / divs[i];
        return h;
    endfunction

    function automatic logic [OUT_FRAC_BITS:0] round_signed(logic [63:0] p, logic neg);
        logic [63:0] m;
        logic [63:0] lim;
        m   = (p + (64'd1 << (61 - OUT_FRAC_BITS))) >> (62 - OUT_FRAC_BITS);
        lim = 64'd1 << OUT_FRAC_BITS;
        if (neg) begin
            if (m > lim) m = lim;
            m = 64'd0 - m;
        end else if (m > lim - 1) begin
            m = lim - 1;
        end
        return m[OUT_FRAC_BITS:0];
    endfunction

    function automatic t_out_item sample_direction(t_in_item it);
        logic [63:0] turn, v31, cos_t, sin_t, r, a, a2, c, s, tmp, cx, sy, z;
        logic [1:0]  quad;
        logic        nx, ny;
        t_out_item   res;
        turn = 64'(it.u_azimuth) << (32 - IN_BITS);
        v31  = (64'(it.u_polar) << (32 - IN_BITS)) >> 1;
        if (!it.func) begin
            cos_t = v31;
            sin_t = int_sqrt((64'd1 << 62) - v31 * v31);
        end else begin
            cos_t = int_sqrt(((64'd1 << 31) - v31) << 31);
            sin_t = int_sqrt(v31 << 31);
        end
        quad = turn[31:30];
        r    = turn & 64'h3FFF_FFFF;
        a    = (r > (64'd1 << 29)) ? (64'd1 << 30) - r : r;
        a    = (a * 64'd3373259426) >> 30;
        a2   = (a * a) >> 31;
        c    = taylor(a2, 1'b0);
        s    = (a * taylor(a2, 1'b1)) >> 31;
        if (r > (64'd1 << 29)) begin
            tmp = c;
            c   = s;
            s   = tmp;
        end
        nx = 0;
        ny = 0;
        case (quad)
            2'd0: begin cx = c; sy = s; end
            2'd1: begin cx = s; sy = c; nx = 1; end
            2'd2: begin cx = c; sy = s; nx = 1; ny = 1; end
            default: begin cx = s; sy = c; ny = 1; end
        endcase
        res.dir_x = round_signed(sin_t * cx, nx);
        res.dir_y = round_signed(sin_t * sy, ny);
        z = (cos_t + (64'd1 << (30 - OUT_FRAC_BITS))) >> (31 - OUT_FRAC_BITS);
        if (z > (64'd1 << OUT_FRAC_BITS) - 1) z = (64'd1 << OUT_FRAC_BITS) - 1;
        res.dir_z = z[OUT_FRAC_BITS-1:0];
        return res;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    initial begin
        o_errors  = 0;
        o_results = 0;
    end

    assign o_pending = dir_queue.size();

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_valid && o_ready) dir_queue.push_back(sample_direction(i_data));
            if (o_valid && i_ready) begin
                o_results++;
                if (dir_queue.size() == 0) begin
                    report("unexpected transaction", 0, 0);
                end else begin
                    want = dir_queue.pop_front();
                    if (o_data.dir_x !== want.dir_x) report("dir_x", o_data.dir_x, want.dir_x);
                    if (o_data.dir_y !== want.dir_y) report("dir_y", o_data.dir_y, want.dir_y);
                    if (o_data.dir_z !== want.dir_z) report("dir_z", o_data.dir_z, want.dir_z);
                end
            end
        end
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import hds_pkg::*;

    localparam int LATENCY = 56;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1850;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_data;
    int        errors, pending, results;
    int        idle_cycles;
    int        sent;
    logic      sink_hold;

    hemisphere_direction_sampler uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    hds_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send(logic func, logic [IN_BITS-1:0] az, logic [IN_BITS-1:0] pol);
        i_valid          <= 1'b1;
        i_data.func      <= func;
        i_data.u_azimuth <= az;
        i_data.u_polar   <= pol;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic pause_sender(int n);
        i_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    function automatic logic [IN_BITS-1:0] pick_fraction();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return {IN_BITS{1'b1}};
            2: return IN_BITS'(1) << $urandom_range(0, IN_BITS - 1);
            3: return IN_BITS'($urandom_range(0, 3)) << (IN_BITS - 2);
            default: return IN_BITS'($urandom);
        endcase
    endfunction

    // receiver: random stalls, with a quiet stretch in the middle
    initial begin
        int g;
        i_ready   = 1'b0;
        sink_hold = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (sink_hold || (sent > 600 && sent < 900)) begin
                i_ready <= 1'b1;
            end else begin
                g = gap_length();
                if (g == 0) begin
                    i_ready <= 1'b1;
                end else begin
                    i_ready <= 1'b0;
                    repeat (g - 1) @(negedge i_clk);
                end
            end
        end
    end

    // watchdog
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog expired with %0d results outstanding", pending);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        int g;
        logic [IN_BITS-1:0] corners [6];
        corners = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000, 16'h2000};
        sent    = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int f = 0; f < 2; f++) begin
            for (int k = 0; k < 6; k++) send(f[0], corners[k], corners[(k * 5 + f) % 6]);
        end
        send(1'b0, 16'h1FFF, 16'h0001);
        send(1'b1, 16'h6001, 16'h7FFF);
        send(1'b0, 16'hA000, 16'h0000);
        send(1'b1, 16'hE000, 16'hFFFF);
        send(1'b0, 16'h5555, 16'hAAAA);
        send(1'b1, 16'hAAAA, 16'h5555);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            g = (n > 600 && n < 900) ? 0 : gap_length();
            if (g > 0) pause_sender(g);
            if (n == RANDOM_ITEMS / 2) begin
                i_valid <= 1'b0;
                while (pending != 0) @(negedge i_clk);
            end
            send(1'($urandom), pick_fraction(), pick_fraction());
        end
        i_valid <= 1'b0;
        sink_hold = 1'b1;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);

        $display("sent %0d directions in both modes, checked %0d results", sent, results);
        $display("covered quadrant edges, polar extremes and random stalls on both sides");
        if (errors == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: hemisphere_direction_sampler.f
+incdir+hw/rtl
hw/rtl/hds_pkg.sv
hw/rtl/hds_sqrt_cell.sv
hw/rtl/hds_series_cell.sv
hw/rtl/hemisphere_direction_sampler.sv
hw/rtl/hds_checker.sv
bench/hds_checker.sv
bench/tb_top.sv
